// ----- rtl/swmf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmf_pkg
// Shared types and constants for the square window morphology filter.
// ----------------------------------------------------------------------------

package swmf_pkg;

    localparam int PIX_W     = 8;
    localparam int POS_OUT_W = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 11;
    localparam int RAD_W     = 2;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 3'd0,
        CFG_RADIUS = 3'd1,
        CFG_WIDTH  = 3'd2,
        CFG_HEIGHT = 3'd3
    } cfg_index_t;

    typedef enum logic {
        MODE_ERODE  = 1'b0,
        MODE_DILATE = 1'b1
    } mode_t;

    typedef struct packed {
        logic              shift;
        mode_t             mode;
        logic [RAD_W-1:0]  radius;
    } cell_ctrl_t;

    function automatic logic [PIX_W-1:0] pick_extreme(
        input mode_t            mode,
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b
    );
        logic b_wins;
        b_wins = (mode == MODE_DILATE) ? (b > a) : (b < a);
        return b_wins ? b : a;
    endfunction

    function automatic logic [PIX_W-1:0] extreme_identity(input mode_t mode);
        return (mode == MODE_DILATE) ? '0 : PIX_MAX;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/swmf_line_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmf_line_store
// One row memory per line slot; all rows read at the same column each beat,
// the current slot written with the incoming pixel.
// ----------------------------------------------------------------------------

module swmf_line_store
    import swmf_pkg::*;
#(
    parameter int ROWS   = 7,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int SLOT_W = 3
)
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [SLOT_W-1:0] wr_slot,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [PIX_W-1:0]  wr_data,
    output logic      [PIX_W-1:0]  rd_data [ROWS]
);

    for (genvar m = 0; m < ROWS; m++) begin : g_row
        logic [PIX_W-1:0] mem [DEPTH];
        logic [PIX_W-1:0] q_reg;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (wr_slot == SLOT_W'(m))
                begin
                    mem[addr] <= wr_data;
                end
                q_reg <= mem[addr];
            end
        end

        assign rd_data[m] = q_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/swmf_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmf_cell
// One column tap of the horizontal window: holds a column extreme, passes it
// to its neighbor on shift, and, when within the window, folds it into the
// running window extreme.

module swmf_cell
    import swmf_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  wire logic             clk,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic [PIX_W-1:0] col_in,
    output logic      [PIX_W-1:0] col_out,
    input  wire logic [PIX_W-1:0] acc_in,
    output logic      [PIX_W-1:0] acc_out
);

    logic [PIX_W-1:0] col_reg;
    logic             in_window;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            col_reg <= col_in;
        end
    end

    assign in_window = ((32'(ctrl.radius) << 1) >= IDX);
    assign col_out   = col_reg;
    assign acc_out   = in_window ? pick_extreme(ctrl.mode, acc_in, col_reg) : acc_in;

endmodule

`default_nettype wire

// ----- rtl/square_window_morphology_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// square_window_morphology_filter
// Grayscale erosion / dilation over a square window of side 2*radius+1.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order while pix_stall is low; each
// result passes through the stage 1, stage 2 and output registers. Each of
// the 2*MAX_RADIUS+1 line slots is its own memory, so a whole column of the
// window is read at once; the column extreme then enters a row of tap
// cells that forms the horizontal extreme. The line store is not cleared
// after reset and needs no start-up pass. Any register write restarts the
// frame at (0,0); write registers only while the block is idle.
// ----------------------------------------------------------------------------

module square_window_morphology_filter
    import swmf_pkg::*;
#(
    parameter int MAX_RADIUS = 3,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pix_valid,
    output logic                      pix_stall,
    input  wire logic [PIX_W-1:0]     pixel_in,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output logic      [POS_OUT_W-1:0] out_x,
    output logic      [POS_OUT_W-1:0] out_y,
    output logic      [PIX_W-1:0]     out_pixel,
    output logic                      frame_last,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int ROWS   = 2 * MAX_RADIUS + 1;
    localparam int SLOT_W = $clog2(ROWS);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);

    // configuration
    mode_t                mode_reg;
    logic [RAD_W-1:0]     radius_reg;
    logic [CFG_DAT_W-1:0] width_reg;
    logic [CFG_DAT_W-1:0] height_reg;
    logic                 restart;

    logic [RAD_W-1:0]     r_eff;
    logic [COL_W:0]       w_eff;
    logic [ROW_W:0]       h_eff;

    // position
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              row_end, frame_end;

    // pipeline control
    logic adv, accept;

    // stage 1
    logic              v1_reg, emit1_reg, full1_reg, last1_reg;
    logic [COL_W-1:0]  cx1_reg;
    logic [ROW_W-1:0]  cy1_reg;
    logic [PIX_W-1:0]  pix1_reg;
    logic [SLOT_W-1:0] slot1_reg;
    logic [PIX_W-1:0]  rd_data [ROWS];
    logic [PIX_W-1:0]  col_ext;

    // stage 2
    logic              emit2_reg, full2_reg, last2_reg;
    logic [COL_W-1:0]  cx2_reg;
    logic [ROW_W-1:0]  cy2_reg;

    // output
    logic                 res_valid_reg;
    logic [POS_OUT_W-1:0] out_x_reg, out_y_reg;
    logic [PIX_W-1:0]     out_pixel_reg;
    logic                 frame_last_reg;

    // tap chain
    cell_ctrl_t       cell_ctrl;
    logic [PIX_W-1:0] col_link [ROWS+1];
    logic [PIX_W-1:0] acc_link [ROWS+1];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        restart = 1'b0;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODE,
                CFG_RADIUS,
                CFG_WIDTH,
                CFG_HEIGHT: restart = 1'b1;
                default:    restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_ERODE;
            radius_reg <= RAD_W'(3);
            width_reg  <= CFG_DAT_W'(640);
            height_reg <= CFG_DAT_W'(480);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODE:   mode_reg   <= mode_t'(cfg_data[0]);
                CFG_RADIUS: radius_reg <= cfg_data[RAD_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        r_eff = (32'(radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_reg;

        if (width_reg == '0)
            w_eff = (COL_W+1)'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = (COL_W+1)'(MAX_WIDTH);
        else
            w_eff = (COL_W+1)'(width_reg);

        if (height_reg == '0)
            h_eff = (ROW_W+1)'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = (ROW_W+1)'(MAX_HEIGHT);
        else
            h_eff = (ROW_W+1)'(height_reg);
    end

    // handshake
    assign adv       = !res_valid_reg || !res_stall;
    assign accept    = pix_valid && adv;
    assign pix_stall = !adv;

    // frame position
    always_comb
    begin
        row_end   = ((COL_W+1)'(col_reg) + (COL_W+1)'(1)) == w_eff;
        frame_end = row_end && (((ROW_W+1)'(row_reg) + (ROW_W+1)'(1)) == h_eff);
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (accept)
        begin
            if (!row_end)
            begin
                col_next = col_reg + COL_W'(1);
            end
            else
            begin
                col_next = '0;
                if (frame_end)
                begin
                    row_next  = '0;
                    slot_next = '0;
                end
                else
                begin
                    row_next  = row_reg + ROW_W'(1);
                    slot_next = (32'(slot_reg) == ROWS - 1) ? '0 : slot_reg + SLOT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (restart)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    // line store
    swmf_line_store #(
        .ROWS   (ROWS),
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W),
        .SLOT_W (SLOT_W)
    ) u_line_store (
        .clk     (clk),
        .en      (accept),
        .wr_slot (slot_reg),
        .addr    (col_reg),
        .wr_data (pixel_in),
        .rd_data (rd_data)
    );

    // stage 1 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            emit1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= accept;
            emit1_reg <= accept && (col_reg >= COL_W'(r_eff)) && (row_reg >= ROW_W'(r_eff));
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            full1_reg <= (col_reg >= COL_W'({r_eff, 1'b0})) &&
                         (row_reg >= ROW_W'({r_eff, 1'b0}));
            last1_reg <= frame_end;
            cx1_reg   <= col_reg - COL_W'(r_eff);
            cy1_reg   <= row_reg - ROW_W'(r_eff);
            pix1_reg  <= pixel_in;
            slot1_reg <= slot_reg;
        end
    end

    // column extreme: rows y-1 .. y-2r come from the slots behind the current one
    always_comb
    begin
        logic [SLOT_W:0] slot_gap;
        col_ext = pix1_reg;
        for (int m = 0; m < ROWS; m++)
        begin
            if (32'(slot1_reg) >= m)
                slot_gap = (SLOT_W+1)'(32'(slot1_reg) - m);
            else
                slot_gap = (SLOT_W+1)'(32'(slot1_reg) + ROWS - m);
            if ((slot_gap != '0) && (slot_gap <= (SLOT_W+1)'({r_eff, 1'b0})))
            begin
                col_ext = pick_extreme(mode_reg, col_ext, rd_data[m]);
            end
        end
    end

    // tap chain
    assign cell_ctrl.shift  = adv && v1_reg;
    assign cell_ctrl.mode   = mode_reg;
    assign cell_ctrl.radius = r_eff;
    assign col_link[0]      = col_ext;
    assign acc_link[0]      = extreme_identity(mode_reg);

    for (genvar i = 0; i < ROWS; i++) begin : g_cell
        swmf_cell #(
            .IDX (i)
        ) u_cell (
            .clk     (clk),
            .ctrl    (cell_ctrl),
            .col_in  (col_link[i]),
            .col_out (col_link[i+1]),
            .acc_in  (acc_link[i]),
            .acc_out (acc_link[i+1])
        );
    end

    // stage 2 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit2_reg <= 1'b0;
        end
        else if (adv)
        begin
            emit2_reg <= emit1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit1_reg)
        begin
            full2_reg <= full1_reg;
            last2_reg <= last1_reg;
            cx2_reg   <= cx1_reg;
            cy2_reg   <= cy1_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= emit2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit2_reg)
        begin
            out_x_reg      <= POS_OUT_W'(cx2_reg);
            out_y_reg      <= POS_OUT_W'(cy2_reg);
            out_pixel_reg  <= full2_reg ? acc_link[ROWS] : '0;
            frame_last_reg <= last2_reg;
        end
    end

    assign res_valid  = res_valid_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_pixel  = out_pixel_reg;
    assign frame_last = frame_last_reg;

endmodule

`default_nettype wire
